### rtl/dstu_pkg.sv
`timescale 1ns / 1ps
// shared types, character codes and unit scales for the duration parser
// no dependencies; imported by every module of the block
package dstu_pkg;

    // character codes
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_P  = 8'h50;
    localparam logic [7:0] CH_T  = 8'h54;
    localparam logic [7:0] CH_Y  = 8'h59;
    localparam logic [7:0] CH_UD = 8'h44;
    localparam logic [7:0] CH_UH = 8'h48;
    localparam logic [7:0] CH_UM = 8'h4D;
    localparam logic [7:0] CH_US = 8'h53;
    localparam logic [7:0] CH_UL = 8'h4C;
    localparam logic [7:0] CH_LD = 8'h64;
    localparam logic [7:0] CH_LH = 8'h68;
    localparam logic [7:0] CH_LM = 8'h6D;
    localparam logic [7:0] CH_LS = 8'h73;
    localparam logic [7:0] CH_LL = 8'h6C;

    localparam int DATA_W = 64;
    localparam int ARG_W  = 4;
    localparam int NUM_FIELDS = 6;
    localparam int FLD_W  = 3;

    // iso unit field slots
    localparam logic [ARG_W-1:0] FLD_YEARS   = 4'd0;
    localparam logic [ARG_W-1:0] FLD_MONTHS  = 4'd1;
    localparam logic [ARG_W-1:0] FLD_DAYS    = 4'd2;
    localparam logic [ARG_W-1:0] FLD_HOURS   = 4'd3;
    localparam logic [ARG_W-1:0] FLD_MINUTES = 4'd4;
    localparam logic [ARG_W-1:0] FLD_SECS    = 4'd5;

    // plain mode unit codes
    localparam logic [ARG_W-1:0] UNIT_DAY  = 4'd0;
    localparam logic [ARG_W-1:0] UNIT_HOUR = 4'd1;
    localparam logic [ARG_W-1:0] UNIT_MIN  = 4'd2;
    localparam logic [ARG_W-1:0] UNIT_SEC  = 4'd3;
    localparam logic [ARG_W-1:0] UNIT_MS   = 4'd4;

    // multiplier: 64-bit operand times a 48-bit constant, 16 bits a cycle
    localparam int CHUNK_W    = 16;
    localparam int MUL_CHUNKS = 3;
    localparam int K_W        = CHUNK_W * MUL_CHUNKS;
    localparam int CNT_W      = 2;
    localparam int SH_W       = 6;

    localparam logic [K_W-1:0] K_DAY_US  = 48'd86400000000;
    localparam logic [K_W-1:0] K_HOUR_US = 48'd3600000000;
    localparam logic [K_W-1:0] K_MIN_US  = 48'd60000000;
    localparam logic [K_W-1:0] K_SEC_US  = 48'd1000000;
    localparam logic [K_W-1:0] K_MS_US   = 48'd1000;
    localparam logic [K_W-1:0] K_YEAR_D  = 48'd365;
    localparam logic [K_W-1:0] K_MONTH_D = 48'd30;
    localparam logic [K_W-1:0] K_DAY_H   = 48'd24;
    localparam logic [K_W-1:0] K_HOUR_S  = 48'd3600;
    localparam logic [K_W-1:0] K_MIN_S   = 48'd60;

    // queue depth between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = 1;
    localparam int QCW    = 2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DIGIT,
        OP_CLEAR,
        OP_STORE,
        OP_UNIT
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [ARG_W-1:0] arg;
        logic             last;
        logic             iso;
    } t_item;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_SETUP,
        BS_MAC,
        BS_EMIT
    } t_bstate;

    // final iso conversion steps, each one multiply-accumulate
    typedef enum logic [2:0] {
        IS_YEARS,
        IS_MONTHS,
        IS_HOURS,
        IS_SECS,
        IS_MINUTES,
        IS_MICRO
    } t_iso_step;

    typedef struct packed {
        logic pop;
        logic emit;
        logic busy;
    } t_back_stat;

    function automatic logic [K_W-1:0] unit_scale(input logic [ARG_W-1:0] u);
        logic [K_W-1:0] k;
        unique case (u)
            UNIT_DAY:  k = K_DAY_US;
            UNIT_HOUR: k = K_HOUR_US;
            UNIT_MIN:  k = K_MIN_US;
            UNIT_SEC:  k = K_SEC_US;
            UNIT_MS:   k = K_MS_US;
            default:   k = '0;
        endcase
        return k;
    endfunction

endpackage

### rtl/duration_string_to_microseconds.sv
`timescale 1ns / 1ps
// top level of the duration string parser: front, queue, back
// depends on dstu_pkg, dstu_front, dstu_fifo, dstu_back

// Reads a duration string one byte per request and, on the request marked
// tlast, returns the length in microseconds as a 64-bit two's complement value
// that wraps on overflow. A string whose first byte is 'P' is read as ISO 8601
// (Y, M, D, H, S store the number read so far, 'T' turns M into minutes, a year
// is 365 days and a month 30 days); any other string adds number times unit for
// d/h/m/s/l in either case. Unknown bytes are skipped; tuser set means the
// request carries no byte, which makes an empty string with tlast give zero.
// The front takes one byte per cycle while its two-entry queue has room. In
// the back a digit or an ISO unit letter is handled in the idle state; a plain
// unit letter goes through a 64 x 16 multiplier that works through the 48-bit
// unit scale in three chunks and then makes the last add, and the close of an
// ISO string runs six multiply-accumulate passes that fold the unit fields
// together. The result waits in an output register, so the back moves on to
// the next string while it is held.
module duration_string_to_microseconds (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    input  logic        i_s_axis_tlast,   // last
    input  logic        i_s_axis_tuser,   // [0] no_char
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic signed [63:0] o_m_axis_tdata  // [63:0] duration_us
);
    import dstu_pkg::*;

    // front to queue
    logic       w_push;
    t_item      w_push_item;
    logic       w_full;
    // queue to back
    logic       w_q_valid;
    t_item      w_q_item;
    t_back_stat w_stat;

    dstu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_char    (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .i_no_char (i_s_axis_tuser),
        .o_push    (w_push),
        .o_item    (w_push_item),
        .i_full    (w_full)
    );

    // decouples byte intake from multi-cycle work in the back
    dstu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_stat.pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    dstu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_item      (w_q_item),
        .o_stat      (w_stat),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

    // the back only takes items the queue actually holds
    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.pop |-> w_q_valid)
        else $error("back popped an empty queue");

    // the front never pushes into a full queue
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("front pushed into a full queue");

    // a new result only appears after the back finished a string
    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_stat.emit))
        else $error("result valid without a finished string");

    // popping happens only while the back sits idle
    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.pop |-> !w_stat.busy)
        else $error("back popped while busy");

endmodule

### rtl/dstu_front.sv
`timescale 1ns / 1ps
// front end: accepts string bytes, tracks mode and classifies each byte
// depends on dstu_pkg
module dstu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_char,
    input  logic          i_last,
    input  logic          i_no_char,
    output logic          o_push,
    output dstu_pkg::t_item o_item,
    input  logic          i_full
);
    import dstu_pkg::*;

    logic  r_start, r_iso, r_time;
    logic  n_start, n_iso, n_time;
    t_op   w_op;
    logic [ARG_W-1:0] w_arg;
    logic  w_acc;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && !i_full;

    always_comb begin
        w_op    = OP_NONE;
        w_arg   = '0;
        n_start = r_start;
        n_iso   = r_iso;
        n_time  = r_time;
        if (!i_no_char) begin
            n_start = 1'b0;
            if (r_start && i_char == CH_P) begin
                n_iso = 1'b1;
            end else if (i_char >= CH_0 && i_char <= CH_9) begin
                w_op  = OP_DIGIT;
                w_arg = ARG_W'(i_char - CH_0);
            end else if (r_iso) begin
                unique case (i_char)
                    CH_T: begin
                        w_op   = OP_CLEAR;
                        n_time = 1'b1;
                    end
                    CH_Y: begin
                        w_op  = OP_STORE;
                        w_arg = FLD_YEARS;
                    end
                    CH_UM: begin
                        w_op  = OP_STORE;
                        w_arg = r_time ? FLD_MINUTES : FLD_MONTHS;
                    end
                    CH_UD: begin
                        w_op  = OP_STORE;
                        w_arg = FLD_DAYS;
                    end
                    CH_UH: begin
                        w_op  = OP_STORE;
                        w_arg = FLD_HOURS;
                    end
                    CH_US: begin
                        w_op  = OP_STORE;
                        w_arg = FLD_SECS;
                    end
                    default: w_op = OP_NONE;
                endcase
            end else begin
                unique case (i_char) inside
                    CH_LD, CH_UD: begin
                        w_op  = OP_UNIT;
                        w_arg = UNIT_DAY;
                    end
                    CH_LH, CH_UH: begin
                        w_op  = OP_UNIT;
                        w_arg = UNIT_HOUR;
                    end
                    CH_LM, CH_UM: begin
                        w_op  = OP_UNIT;
                        w_arg = UNIT_MIN;
                    end
                    CH_LS, CH_US: begin
                        w_op  = OP_UNIT;
                        w_arg = UNIT_SEC;
                    end
                    CH_LL, CH_UL: begin
                        w_op  = OP_UNIT;
                        w_arg = UNIT_MS;
                    end
                    default: w_op = OP_NONE;
                endcase
            end
        end
    end

    // bytes with no effect are dropped unless they close the string
    assign o_push      = w_acc && (i_last || w_op != OP_NONE);
    assign o_item.op   = w_op;
    assign o_item.arg  = w_arg;
    assign o_item.last = i_last;
    assign o_item.iso  = n_iso;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b1;
            r_iso   <= 1'b0;
            r_time  <= 1'b0;
        end else if (w_acc) begin
            if (i_last) begin
                r_start <= 1'b1;
                r_iso   <= 1'b0;
                r_time  <= 1'b0;
            end else begin
                r_start <= n_start;
                r_iso   <= n_iso;
                r_time  <= n_time;
            end
        end
    end

endmodule

### rtl/dstu_fifo.sv
`timescale 1ns / 1ps
// short queue of classified items between front and back
// depends on dstu_pkg
module dstu_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dstu_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output dstu_pkg::t_item o_item
);
    import dstu_pkg::*;

    t_item            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QCW-1:0]   r_cnt;
    logic             w_push, w_pop;

    assign o_full  = r_cnt == QCW'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QCW'(w_push) - QCW'(w_pop);
        end
    end

endmodule

### rtl/dstu_back.sv
`timescale 1ns / 1ps
// back end: number accumulator, unit fields, chunked multiply-accumulate,
// final conversion and output register; depends on dstu_pkg
module dstu_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  dstu_pkg::t_item             i_item,
    output dstu_pkg::t_back_stat        o_stat,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [dstu_pkg::DATA_W-1:0] o_out_data
);
    import dstu_pkg::*;

    t_bstate          r_state, n_state;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic [DATA_W-1:0] r_fields [NUM_FIELDS];
    logic [DATA_W-1:0] n_fields [NUM_FIELDS];
    logic [DATA_W-1:0] r_total, n_total;
    logic [DATA_W-1:0] r_mul_a, n_mul_a;
    logic [K_W-1:0]    r_mul_k, n_mul_k;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DATA_W-1:0] r_prod, n_prod;
    logic              r_fin, n_fin;
    logic              r_iso_run, n_iso_run;
    t_iso_step         r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_data, n_out_data;

    logic [CHUNK_W-1:0]        w_chunk;
    logic [DATA_W+CHUNK_W-1:0] w_full;
    logic [SH_W-1:0]           w_shamt;
    logic                      w_out_free;
    logic                      w_pop, w_emit;

    assign w_shamt    = {r_cnt, 4'b0000};
    assign w_chunk    = CHUNK_W'(r_mul_k >> w_shamt);
    assign w_full     = r_mul_a * w_chunk;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_fields    = r_fields;
        n_total     = r_total;
        n_mul_a     = r_mul_a;
        n_mul_k     = r_mul_k;
        n_cnt       = r_cnt;
        n_prod      = r_prod;
        n_fin       = r_fin;
        n_iso_run   = r_iso_run;
        n_step      = r_step;
        n_out_valid = (r_out_valid && !i_out_ready);
        n_out_data  = r_out_data;
        w_pop       = 1'b0;
        w_emit      = 1'b0;

        unique case (r_state)
            BS_IDLE: begin
                if (i_valid) begin
                    w_pop = 1'b1;
                    n_fin = i_item.last;
                    unique case (i_item.op)
                        OP_DIGIT: n_acc = (r_acc << 3) + (r_acc << 1)
                                          + DATA_W'(i_item.arg);
                        OP_CLEAR: n_acc = '0;
                        OP_STORE: begin
                            n_fields[i_item.arg[FLD_W-1:0]] = r_acc;
                            n_acc = '0;
                        end
                        OP_UNIT: begin
                            n_mul_a = r_acc;
                            n_mul_k = unit_scale(i_item.arg);
                            n_cnt   = '0;
                            n_acc   = '0;
                        end
                        default: n_acc = r_acc;
                    endcase
                    if (i_item.op == OP_UNIT) begin
                        n_state = BS_MAC;
                    end else if (i_item.last) begin
                        if (i_item.iso) begin
                            n_iso_run = 1'b1;
                            n_step    = IS_YEARS;
                            n_state   = BS_SETUP;
                        end else begin
                            n_state = BS_EMIT;
                        end
                    end
                end
            end
            BS_SETUP: begin
                n_cnt   = '0;
                n_state = BS_MAC;
                unique case (r_step)
                    IS_YEARS: begin
                        n_total = r_fields[FLD_DAYS[FLD_W-1:0]];
                        n_mul_a = r_fields[FLD_YEARS[FLD_W-1:0]];
                        n_mul_k = K_YEAR_D;
                    end
                    IS_MONTHS: begin
                        n_mul_a = r_fields[FLD_MONTHS[FLD_W-1:0]];
                        n_mul_k = K_MONTH_D;
                    end
                    IS_HOURS: begin
                        n_total = r_fields[FLD_HOURS[FLD_W-1:0]];
                        n_mul_a = r_total;
                        n_mul_k = K_DAY_H;
                    end
                    IS_SECS: begin
                        n_total = r_fields[FLD_SECS[FLD_W-1:0]];
                        n_mul_a = r_total;
                        n_mul_k = K_HOUR_S;
                    end
                    IS_MINUTES: begin
                        n_mul_a = r_fields[FLD_MINUTES[FLD_W-1:0]];
                        n_mul_k = K_MIN_S;
                    end
                    IS_MICRO: begin
                        n_total = '0;
                        n_mul_a = r_total;
                        n_mul_k = K_SEC_US;
                    end
                    default: n_state = BS_EMIT;
                endcase
            end
            BS_MAC: begin
                // product of one chunk registered, added the cycle after
                if (r_cnt != CNT_W'(MUL_CHUNKS)) begin
                    n_prod = w_full[DATA_W-1:0] << w_shamt;
                end
                if (r_cnt != '0) begin
                    n_total = r_total + r_prod;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_CHUNKS)) begin
                    if (!r_fin) begin
                        n_state = BS_IDLE;
                    end else if (r_iso_run && r_step != IS_MICRO) begin
                        n_step  = t_iso_step'(r_step + 1'b1);
                        n_state = BS_SETUP;
                    end else begin
                        n_state = BS_EMIT;
                    end
                end
            end
            BS_EMIT: begin
                if (w_out_free) begin
                    w_emit      = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_data  = r_total;
                    n_acc       = '0;
                    n_total     = '0;
                    n_fin       = 1'b0;
                    n_iso_run   = 1'b0;
                    for (int i = 0; i < NUM_FIELDS; i++) begin
                        n_fields[i] = '0;
                    end
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_acc       <= '0;
            r_total     <= '0;
            r_fin       <= 1'b0;
            r_iso_run   <= 1'b0;
            r_step      <= IS_YEARS;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_FIELDS; i++) begin
                r_fields[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_total     <= n_total;
            r_fin       <= n_fin;
            r_iso_run   <= n_iso_run;
            r_step      <= n_step;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_fields    <= n_fields;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul_a    <= n_mul_a;
        r_mul_k    <= n_mul_k;
        r_prod     <= n_prod;
        r_out_data <= n_out_data;
    end

    assign o_stat.pop  = w_pop;
    assign o_stat.emit = w_emit;
    assign o_stat.busy = r_state != BS_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// self-checking bench for duration_string_to_microseconds: directed strings, then random ones
// depends on the block's rtl only; a bench predictor computes expected durations, pinned ones aside

module tb;

    // timing and run shape
    localparam int          RESET_CYCLES = 12;
    localparam int          RANDOM_ITEMS = 1750;
    localparam int          LONG_HOLD    = 400;  // receiver hold-off, long enough to fill the block
    localparam int          DRAIN_CYCLES = 64;   // further wait once every expected result has been seen
    localparam int unsigned RUN_LIMIT_NS = 10_000_000;
    localparam int          MAX_REPORTS  = 10;

    // byte codes the parser reacts to
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_P     = "P";
    localparam logic [7:0] CH_T     = "T";
    localparam logic [7:0] CH_Y     = "Y";
    localparam logic [7:0] CH_UP_D  = "D";
    localparam logic [7:0] CH_UP_H  = "H";
    localparam logic [7:0] CH_UP_M  = "M";
    localparam logic [7:0] CH_UP_S  = "S";
    localparam logic [7:0] CH_UP_L  = "L";
    localparam logic [7:0] CH_LO_D  = "d";
    localparam logic [7:0] CH_LO_H  = "h";
    localparam logic [7:0] CH_LO_M  = "m";
    localparam logic [7:0] CH_LO_S  = "s";
    localparam logic [7:0] CH_LO_L  = "l";

    // unit scales, all arithmetic is 64-bit and wraps
    localparam logic [63:0] US_PER_MS      = 64'd1000;
    localparam logic [63:0] US_PER_SEC     = 64'd1_000_000;
    localparam logic [63:0] US_PER_MIN     = 64'd60 * US_PER_SEC;
    localparam logic [63:0] US_PER_HOUR    = 64'd3600 * US_PER_SEC;
    localparam logic [63:0] US_PER_DAY     = 64'd24 * US_PER_HOUR;
    localparam logic [63:0] DAYS_PER_YEAR  = 64'd365;
    localparam logic [63:0] DAYS_PER_MONTH = 64'd30;
    localparam logic [63:0] HOURS_PER_DAY  = 64'd24;
    localparam logic [63:0] SECS_PER_HOUR  = 64'd3600;
    localparam logic [63:0] SECS_PER_MIN   = 64'd60;

    // slots of the iso unit fields
    typedef enum int {
        U_YEARS,
        U_MONTHS,
        U_DAYS,
        U_HOURS,
        U_MINUTES,
        U_SECS
    } unit_slot_e;

    // one input request; pinned rows carry a duration typed in by hand
    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic        no_char;
        logic        pinned;
        logic [63:0] pinned_us;
    } request_t;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [7:0]         i_s_axis_tdata  = 8'h00;  // [7:0] char_code
    logic               i_s_axis_tlast  = 1'b0;   // last
    logic               i_s_axis_tuser  = 1'b0;   // [0] no_char
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic signed [63:0] o_m_axis_tdata;           // [63:0] duration_us

    // request on the bus, as the input monitor sees it
    logic        cur_pinned    = 1'b0;
    logic [63:0] cur_pinned_us = 64'd0;

    // source-to-sink coordination
    logic hold_req  = 1'b0;
    logic tail_calm = 1'b0;

    request_t    request_q[$];
    logic [63:0] expected_us_q[$];
    int          fail_count = 0;

    // predictor state
    logic        st_at_start;
    logic        st_iso;
    logic        st_time_part;
    logic [63:0] st_number;
    logic [63:0] st_fields[6];
    logic [63:0] st_total;

    duration_string_to_microseconds i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic clear_parse_state();
        st_at_start  = 1'b1;
        st_iso       = 1'b0;
        st_time_part = 1'b0;
        st_number    = '0;
        st_total     = '0;
        for (int k = 0; k < 6; k++) st_fields[k] = '0;
    endtask

    // advance the predictor by one request; a closing request yields the duration
    task automatic parse_step(input request_t r, output logic done, output logic [63:0] dur_us);
        logic [63:0] scale;
        logic [63:0] acc;
        done   = r.last;
        dur_us = '0;
        if (!r.no_char) begin
            if (st_at_start && r.ch == CH_P) begin
                st_iso = 1'b1;
            end else if (r.ch >= CH_ZERO && r.ch <= CH_NINE) begin
                st_number = st_number * 64'd10 + 64'(r.ch - CH_ZERO);
            end else if (st_iso) begin
                case (r.ch)
                    CH_T: begin
                        st_time_part = 1'b1;
                        st_number    = '0;
                    end
                    CH_Y: begin
                        st_fields[U_YEARS] = st_number;
                        st_number          = '0;
                    end
                    CH_UP_M: begin
                        // after the time designator M means minutes
                        st_fields[st_time_part ? U_MINUTES : U_MONTHS] = st_number;
                        st_number = '0;
                    end
                    CH_UP_D: begin
                        st_fields[U_DAYS] = st_number;
                        st_number         = '0;
                    end
                    CH_UP_H: begin
                        st_fields[U_HOURS] = st_number;
                        st_number          = '0;
                    end
                    CH_UP_S: begin
                        st_fields[U_SECS] = st_number;
                        st_number         = '0;
                    end
                    default: ;
                endcase
            end else begin
                case (r.ch)
                    CH_LO_D, CH_UP_D: scale = US_PER_DAY;
                    CH_LO_H, CH_UP_H: scale = US_PER_HOUR;
                    CH_LO_M, CH_UP_M: scale = US_PER_MIN;
                    CH_LO_S, CH_UP_S: scale = US_PER_SEC;
                    CH_LO_L, CH_UP_L: scale = US_PER_MS;
                    default:          scale = '0;
                endcase
                if (scale != '0) begin
                    st_total  = st_total + st_number * scale;
                    st_number = '0;
                end
            end
            st_at_start = 1'b0;
        end
        if (r.last) begin
            if (st_iso) begin
                acc = st_fields[U_YEARS] * DAYS_PER_YEAR + st_fields[U_MONTHS] * DAYS_PER_MONTH
                    + st_fields[U_DAYS];
                acc = (acc * HOURS_PER_DAY + st_fields[U_HOURS]) * SECS_PER_HOUR;
                acc = acc + st_fields[U_MINUTES] * SECS_PER_MIN + st_fields[U_SECS];
                dur_us = acc * US_PER_SEC;
            end else begin
                dur_us = st_total;
            end
            clear_parse_state();
        end
    endtask

    task automatic put(input logic [7:0] ch, input logic last = 1'b0, input logic no_char = 1'b0,
                       input logic pinned = 1'b0, input logic [63:0] pinned_us = 64'd0);
        request_t r;
        r.ch        = ch;
        r.last      = last;
        r.no_char   = no_char;
        r.pinned    = pinned;
        r.pinned_us = pinned_us;
        request_q.push_back(r);
    endtask

    // decimal run, mostly short, sometimes long enough to wrap 64 bits
    task automatic add_number();
        int unsigned n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 4);
        for (int k = 0; k < n; k++) put(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic add_random_string();
        int unsigned kind;
        int unsigned n;
        int          start;
        start = request_q.size();
        kind  = $urandom_range(0, 9);
        if (kind < 4) begin
            // iso string
            if ($urandom_range(0, 7) == 0) put(8'($urandom), 1'b0, 1'b1);
            put(CH_P);
            if ($urandom_range(0, 3) == 0) begin
                // designators in any order, with noise mixed in
                n = $urandom_range(0, 7);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(0, 3) != 0) add_number();
                    case ($urandom_range(0, 8))
                        0: put(CH_Y);
                        1: put(CH_UP_M);
                        2: put(CH_UP_D);
                        3: put(CH_UP_H);
                        4: put(CH_UP_S);
                        5: put(CH_T);
                        6: put(CH_P);
                        7: put(8'($urandom), 1'b0, 1'b1);
                        default: put(8'($urandom));
                    endcase
                end
            end else begin
                if ($urandom_range(0, 1)) begin add_number(); put(CH_Y); end
                if ($urandom_range(0, 1)) begin add_number(); put(CH_UP_M); end
                if ($urandom_range(0, 1)) begin add_number(); put(CH_UP_D); end
                if ($urandom_range(0, 2) != 0) begin
                    put(CH_T);
                    if ($urandom_range(0, 1)) begin add_number(); put(CH_UP_H); end
                    if ($urandom_range(0, 1)) begin add_number(); put(CH_UP_M); end
                    if ($urandom_range(0, 1)) begin add_number(); put(CH_UP_S); end
                end
                if ($urandom_range(0, 5) == 0) add_number();  // dangling value
            end
        end else if (kind < 8) begin
            // plain string: value and unit pairs, with noise mixed in
            n = $urandom_range(0, 4);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 5) != 0) add_number();
                case ($urandom_range(0, 13))
                    0:  put(CH_LO_D);
                    1:  put(CH_UP_D);
                    2:  put(CH_LO_H);
                    3:  put(CH_UP_H);
                    4:  put(CH_LO_M);
                    5:  put(CH_UP_M);
                    6:  put(CH_LO_S);
                    7:  put(CH_UP_S);
                    8:  put(CH_LO_L);
                    9:  put(CH_UP_L);
                    10: put(CH_T);
                    11: put(CH_P);
                    12: put(8'($urandom), 1'b0, 1'b1);
                    default: put(8'($urandom));
                endcase
            end
        end else begin
            // raw noise over the whole byte range
            n = $urandom_range(0, 8);
            for (int k = 0; k < n; k++) put(8'($urandom), 1'b0, ($urandom_range(0, 2) == 0));
        end
        if (request_q.size() == start || $urandom_range(0, 3) == 0)
            put(8'($urandom), 1'b1, 1'b1);
        else
            request_q[request_q.size() - 1].last = 1'b1;
    endtask

    // directed strings; pinned rows hold durations that are obvious by inspection
    task automatic load_directed();
        put(8'h00,   1'b1, 1'b1, 1'b1, 64'd0);  // empty string
        put(8'h00,   1'b1, 1'b0, 1'b1, 64'd0);  // lowest byte, unknown
        put(8'hFF,   1'b1, 1'b0, 1'b1, 64'd0);  // highest byte, unknown
        put(CH_P,    1'b1, 1'b0, 1'b1, 64'd0);  // iso marker with nothing after
        put(CH_NINE, 1'b1, 1'b0, 1'b1, 64'd0);  // value with no unit
        // iso with every designator, byteless lead-in and a stray marker
        put(8'hA5, 1'b0, 1'b1);
        put(CH_P);
        put(CH_ZERO + 8'd1); put(CH_Y);
        put(CH_ZERO + 8'd2); put(CH_UP_M);
        put(CH_ZERO + 8'd3); put(CH_UP_D);
        put(CH_T);
        put(CH_ZERO + 8'd4); put(CH_UP_H);
        put(CH_ZERO + 8'd5); put(CH_UP_M);
        put(CH_P);
        put(CH_ZERO + 8'd6); put(CH_UP_S, 1'b1);
        // plain string, the time designator is just noise here
        put(CH_ZERO + 8'd7); put(CH_LO_D);
        put(CH_T);
        put(CH_ZERO + 8'd9); put(CH_LO_L, 1'b1);
    endtask

    // input monitor feeds the predictor, output monitor checks against it
    always @(posedge i_clk) begin
        request_t    seen;
        logic        done;
        logic [63:0] dur_us;
        logic [63:0] want;
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_us_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result %0d (0x%016h)", o_m_axis_tdata, o_m_axis_tdata);
            end else begin
                want = expected_us_q.pop_front();
                if (o_m_axis_tdata !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("duration mismatch: expected %0d (0x%016h), got %0d (0x%016h)",
                                 $signed(want), want, o_m_axis_tdata, o_m_axis_tdata);
                end
            end
        end
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            seen.ch        = i_s_axis_tdata;
            seen.last      = i_s_axis_tlast;
            seen.no_char   = i_s_axis_tuser;
            seen.pinned    = cur_pinned;
            seen.pinned_us = cur_pinned_us;
            parse_step(seen, done, dur_us);
            if (done) expected_us_q.push_back(seen.pinned ? seen.pinned_us : dur_us);
        end
    end

    // result sink: random stall bursts in some stretches, one long hold-off, calm at the tail
    int   sink_gap     = 0;
    int   sink_hold    = 0;
    int   sink_stretch = 0;
    logic sink_lazy    = 1'b0;
    logic hold_done    = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            sink_hold = LONG_HOLD - 1;
            i_m_axis_tready <= 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold--;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (sink_stretch == 0) begin
                sink_lazy    = ($urandom_range(0, 2) != 0);
                sink_stretch = $urandom_range(50, 300);
            end else begin
                sink_stretch--;
            end
            if (sink_gap > 0) begin
                sink_gap--;
                i_m_axis_tready <= 1'b0;
            end else if (sink_lazy && !tail_calm && $urandom_range(0, 5) == 0) begin
                sink_gap = $urandom_range(1, 15) - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // request source and end of run
    initial begin
        int       n_directed;
        int       hold_at;
        int       calm_from;
        int       src_stretch;
        logic     src_lazy;
        request_t r;
        clear_parse_state();
        load_directed();
        n_directed = request_q.size();
        while (request_q.size() < n_directed + RANDOM_ITEMS) add_random_string();
        hold_at     = n_directed + 300;
        calm_from   = (request_q.size() * 85) / 100;
        src_stretch = 0;
        src_lazy    = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int idx = 0; idx < request_q.size(); idx++) begin
            r = request_q[idx];
            if (idx == hold_at) hold_req <= 1'b1;
            if (idx == calm_from) tail_calm <= 1'b1;
            if (src_stretch == 0) begin
                src_lazy    = ($urandom_range(0, 2) != 0);
                src_stretch = $urandom_range(20, 150);
            end else begin
                src_stretch--;
            end
            if (src_lazy && idx < calm_from && $urandom_range(0, 4) == 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= r.ch;
            i_s_axis_tlast  <= r.last;
            i_s_axis_tuser  <= r.no_char;
            cur_pinned      <= r.pinned;
            cur_pinned_us   <= r.pinned_us;
            @(posedge i_clk);
            while (!o_s_axis_tready) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (expected_us_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### duration_string_to_microseconds.f
rtl/dstu_pkg.sv
rtl/dstu_front.sv
rtl/dstu_fifo.sv
rtl/dstu_back.sv
rtl/duration_string_to_microseconds.sv
verif/tb.sv
